### hdl/top_n_newest_tracker_core_defines.svh
// assertion macros for the newest-entry tracker
// used by the sequencer and the top level
`ifndef TOP_N_NEWEST_TRACKER_CORE_DEFINES_SVH
`define TOP_N_NEWEST_TRACKER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TNT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define TNT_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TNT_ASSERT(lbl, clk, rst_n, prop)
`define TNT_ASSERT_NR(lbl, clk, prop)
`endif
`endif

### hdl/tnt_pkg.sv
// shared types and constants for the newest-entry tracker
// no dependencies
package tnt_pkg;
  localparam int unsigned CntW = 6;
  localparam logic [CntW-1:0] KeepReset = 6'd20;
  localparam logic OpOffer = 1'b0;
  localparam logic OpDump  = 1'b1;

  typedef struct packed {
    logic signed [63:0] secs;
    logic [29:0]        nanos;
    logic [63:0]        size;
    logic [31:0]        tag;
  } entry_t;

  typedef struct packed {
    logic          opcode;
    entry_t        ent;
  } in_item_t;

  typedef struct packed {
    logic          accepted;
    logic [CntW-1:0] held_count;
    logic          entry_valid;
    entry_t        ent;
    logic          last;
  } out_item_t;

  // a newer than b: signed seconds, then unsigned nanos
  function automatic logic key_newer(entry_t a, entry_t b);
    logic r;
    if (a.secs != b.secs) r = (a.secs > b.secs);
    else r = (a.nanos > b.nanos);
    return r;
  endfunction
endpackage

### hdl/tnt_if.sv
// valid/ready channel interface for the tracker
// depends on tnt_pkg
interface tnt_in_if;
  logic valid;
  logic ready;
  tnt_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tnt_out_if;
  logic valid;
  logic ready;
  tnt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tnt_cfg_if;
  logic valid;
  logic ready;
  logic [5:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/tnt_store.sv
// entry memory of the tracker, one write and one registered read port
// depends on tnt_pkg
module tnt_store #(
  parameter int unsigned Depth = 32,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  tnt_pkg::entry_t   wdata,
  input  logic [AW-1:0]     raddr,
  output tnt_pkg::entry_t   rdata
);
  tnt_pkg::entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hdl/tnt_seq.sv
// sequencer: sorted insert by one compare/shift step per slot, and dump
// depends on tnt_pkg, tnt_store, defines header
`include "top_n_newest_tracker_core_defines.svh"
module tnt_seq #(
  parameter int unsigned Capacity = 32,
  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned CW = $clog2(Capacity + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_val,
  output logic                cfg_rdy,
  input  logic                in_v,
  output logic                in_rdy,
  input  tnt_pkg::in_item_t   in_d,
  output logic                out_v,
  input  logic                out_rdy,
  output tnt_pkg::out_item_t  out_d
);
  typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_DRD, S_DWAIT, S_OUT} state_t;
  state_t state_r;
  logic [5:0]     keep_r;
  logic [CW-1:0]  total_r, idx_r;
  tnt_pkg::entry_t new_r;
  logic           chk_r;
  tnt_pkg::out_item_t out_r;
  logic           out_v_r;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  tnt_pkg::entry_t wdata, rdata;
  logic [CW-1:0]   cap;

  tnt_store #(.Depth(Capacity)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign cap = (32'(keep_r) > Capacity) ? CW'(Capacity) : CW'(keep_r);
  assign in_rdy  = (state_r == S_IDLE) && !out_v_r && !cfg_we;
  assign cfg_rdy = (state_r == S_IDLE);
  assign out_v = out_v_r;
  assign out_d = out_r;
  assign raddr = AW'(idx_r - CW'(1));

  // walk from the tail toward the head: shift older entries down by one
  always_comb begin
    we = 1'b0;
    waddr = AW'(idx_r);
    wdata = rdata;
    if (state_r == S_CMP) begin
      we = 1'b1;
      if (idx_r != '0 && !tnt_pkg::key_newer(rdata, new_r) &&
          tnt_pkg::key_newer(new_r, rdata) == 1'b0) begin
        wdata = new_r;
      end else if (idx_r != '0 && tnt_pkg::key_newer(new_r, rdata)) begin
        wdata = rdata;
      end else begin
        wdata = new_r;
      end
      // the check against the oldest slot writes nothing
      if (idx_r >= CW'(Capacity) || chk_r) we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      keep_r  <= tnt_pkg::KeepReset;
      total_r <= '0;
      out_v_r <= 1'b0;
      idx_r   <= '0;
      chk_r   <= 1'b0;
    end else begin
      if (out_v_r && out_rdy && state_r != S_OUT) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_we) begin
            keep_r  <= cfg_val;
            total_r <= '0;
          end else if (in_v && in_rdy) begin
            new_r <= in_d.ent;
            if (in_d.opcode == tnt_pkg::OpDump) begin
              if (total_r == '0) begin
                out_r <= '{accepted: 1'b0, held_count: '0, entry_valid: 1'b0,
                           ent: '0, last: 1'b1};
                out_v_r <= 1'b1;
              end else begin
                idx_r   <= CW'(1);
                state_r <= S_DRD;
              end
            end else if (cap == '0) begin
              out_r <= '{accepted: 1'b0, held_count: 6'(total_r), entry_valid: 1'b0,
                         ent: '0, last: 1'b1};
              out_v_r <= 1'b1;
            end else begin
              // when full, the first compare is against the oldest slot
              idx_r   <= total_r;
              chk_r   <= (total_r >= cap);
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (chk_r) begin
            if (!tnt_pkg::key_newer(new_r, rdata)) begin
              // full and not newer than the oldest: rejected, nothing written
              out_r <= '{accepted: 1'b0, held_count: 6'(total_r), entry_valid: 1'b0,
                         ent: '0, last: 1'b1};
              out_v_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              // oldest slot is the victim, overwritten by the shift
              idx_r   <= idx_r - CW'(1);
              chk_r   <= 1'b0;
              state_r <= S_RD;
            end
          end else if (idx_r == '0 || !tnt_pkg::key_newer(new_r, rdata)) begin
            if (total_r < cap) total_r <= total_r + CW'(1);
            out_r <= '{accepted: 1'b1,
                       held_count: 6'((total_r < cap) ? total_r + CW'(1) : total_r),
                       entry_valid: 1'b0, ent: '0, last: 1'b1};
            out_v_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r - CW'(1);
            state_r <= S_RD;
          end
        end
        S_DRD: state_r <= S_DWAIT;
        S_DWAIT: state_r <= S_OUT;
        S_OUT: begin
          if (!out_v_r || out_rdy) begin
            out_r <= '{accepted: 1'b0, held_count: 6'(total_r), entry_valid: 1'b1,
                       ent: rdata, last: (idx_r == total_r)};
            out_v_r <= 1'b1;
            if (idx_r == total_r) state_r <= S_IDLE;
            else begin
              idx_r   <= idx_r + CW'(1);
              state_r <= S_DRD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `TNT_ASSERT(a_total_cap, clk, rst_n, (total_r <= CW'(Capacity)))
  `TNT_ASSERT(a_busy_no_in, clk, rst_n, (state_r != S_IDLE) |-> !in_rdy)
  `TNT_ASSERT(a_out_hold, clk, rst_n, (out_v_r && !out_rdy) |=> $stable(out_r))
endmodule

### hdl/top_n_newest_tracker_core.sv
// top level of the newest-entry tracker
// depends on tnt_pkg, tnt_if, tnt_seq, defines header
//
// channels: in (offer or dump item), out (result items), cfg (keep_count write)
// all are valid/ready; a transfer happens when both are high at a clk edge.
// an offer walks the sorted store from its tail toward the head, one slot
// per read/compare step (states S_RD and S_CMP) through the store's read
// port, and gives one result; an offer rejected by a full store ends after
// its compare against the oldest slot and writes nothing.
// with keep_count 0 an offer gives its result in the cycle after it is taken.
// a dump reads the entries one at a time, newest first, last marks the end;
// an empty dump gives one result with entry_valid low.
// the block takes one item at a time; in_ready is low while it works, while
// a result waits and while a cfg write is offered; a stalled receiver holds
// the sequencer.
// a keep_count write empties the store; keep_count is clamped to CAPACITY.
// rst_n (synchronous, active low) empties the store and sets keep_count 20.
// no clearing pass: slots beyond the held count are never read.
`include "top_n_newest_tracker_core_defines.svh"
module top_n_newest_tracker_core #(
  parameter int unsigned CAPACITY = 32
) (
  input logic    clk,
  input logic    rst_n,
  tnt_in_if.sink   in_ch,
  tnt_out_if.source out_ch,
  tnt_cfg_if.sink  cfg_ch
);
  tnt_seq #(.Capacity(CAPACITY)) u_seq (
    .clk, .rst_n,
    .cfg_we(cfg_ch.valid), .cfg_val(cfg_ch.data), .cfg_rdy(cfg_ch.ready),
    .in_v(in_ch.valid), .in_rdy(in_ch.ready), .in_d(in_ch.data),
    .out_v(out_ch.valid), .out_rdy(out_ch.ready), .out_d(out_ch.data)
  );

  `TNT_ASSERT(a_one_side, clk, rst_n, !(in_ch.ready && in_ch.valid && out_ch.valid))
  `TNT_ASSERT(a_cfg_idle, clk, rst_n, (cfg_ch.valid && cfg_ch.ready) |-> !in_ch.ready)
  `TNT_ASSERT(a_count_rng, clk, rst_n, out_ch.valid |-> (out_ch.data.held_count <= 6'd32))
endmodule

### test/tb_top_n_newest_tracker_core.sv
// self-checking testbench for the newest-entry tracker core
// depends on tnt_pkg and the channel interfaces in tnt_if
module tb_top_n_newest_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cap = 32;
  localparam int IdleLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  tnt_in_if in_ch();
  tnt_out_if out_ch();
  tnt_cfg_if cfg_ch();

  top_n_newest_tracker_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // predictor state: store kept newest first
  tnt_pkg::entry_t kept_q[$];
  int unsigned keep_lim = 20;
  tnt_pkg::out_item_t results_due[$];
  tnt_pkg::in_item_t items_pending[$];
  int fail_cnt = 0;
  int offers_seen = 0, dumps_seen = 0, results_seen = 0;
  int idle_cycles = 0;
  int in_gap = 0, out_gap = 0;
  bit hold_sender = 1'b0;

  function automatic void set_keep(logic [5:0] v);
    keep_lim = (v > Cap) ? Cap : v;
    kept_q.delete();
  endfunction

  function automatic bit newer(tnt_pkg::entry_t a, tnt_pkg::entry_t b);
    if (a.secs != b.secs) return a.secs > b.secs;
    return a.nanos > b.nanos;
  endfunction

  function automatic void predict_results(tnt_pkg::in_item_t it);
    tnt_pkg::out_item_t r;
    int pos;
    bit acc;
    if (it.opcode == tnt_pkg::OpOffer) begin
      acc = 1'b0;
      if (keep_lim != 0) begin
        if (kept_q.size() >= keep_lim && newer(it.ent, kept_q[$])) begin
          void'(kept_q.pop_back());
        end
        if (kept_q.size() < keep_lim) begin
          pos = 0;
          while (pos < kept_q.size() && !newer(it.ent, kept_q[pos])) pos++;
          kept_q.insert(pos, it.ent);
          acc = 1'b1;
        end
      end
      r = '0;
      r.accepted = acc;
      r.held_count = 6'(kept_q.size());
      r.last = 1'b1;
      results_due.push_back(r);
    end else if (kept_q.size() == 0) begin
      r = '0;
      r.last = 1'b1;
      results_due.push_back(r);
    end else begin
      foreach (kept_q[i]) begin
        r = '0;
        r.held_count = 6'(kept_q.size());
        r.entry_valid = 1'b1;
        r.ent = kept_q[i];
        r.last = (i == kept_q.size() - 1);
        results_due.push_back(r);
      end
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      in_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_results(in_ch.data);
        if (in_ch.data.opcode == tnt_pkg::OpOffer) offers_seen++;
        else dumps_seen++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (items_pending.size() > 0 && !hold_sender) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= items_pending.pop_front();
          in_gap <= ($urandom_range(3) == 0) ? 0 : $urandom_range(18);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tnt_pkg::out_item_t exp_r;
    tnt_pkg::out_item_t got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results_seen++;
        if (results_due.size() == 0) begin
          $error("result item with nothing expected");
          fail_cnt++;
        end else begin
          exp_r = results_due.pop_front();
          if (got.accepted !== exp_r.accepted) begin
            $error("accepted exp %0d got %0d", exp_r.accepted, got.accepted); fail_cnt++;
          end
          if (got.held_count !== exp_r.held_count) begin
            $error("held_count exp %0d got %0d", exp_r.held_count, got.held_count);
            fail_cnt++;
          end
          if (got.entry_valid !== exp_r.entry_valid) begin
            $error("entry_valid exp %0d got %0d", exp_r.entry_valid, got.entry_valid);
            fail_cnt++;
          end
          if (got.ent.secs !== exp_r.ent.secs) begin
            $error("out_seconds exp %0d got %0d", exp_r.ent.secs, got.ent.secs); fail_cnt++;
          end
          if (got.ent.nanos !== exp_r.ent.nanos) begin
            $error("out_nanos exp %0d got %0d", exp_r.ent.nanos, got.ent.nanos); fail_cnt++;
          end
          if (got.ent.size !== exp_r.ent.size) begin
            $error("out_size exp %0h got %0h", exp_r.ent.size, got.ent.size); fail_cnt++;
          end
          if (got.ent.tag !== exp_r.ent.tag) begin
            $error("out_tag exp %0h got %0h", exp_r.ent.tag, got.ent.tag); fail_cnt++;
          end
          if (got.last !== exp_r.last) begin
            $error("last exp %0d got %0d", exp_r.last, got.last); fail_cnt++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid && out_ch.ready)
          out_gap <= ($urandom_range(3) == 0) ? 0 : $urandom_range(18);
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic tnt_pkg::in_item_t make_item(logic op, logic [63:0] s,
                                                  logic [29:0] n);
    tnt_pkg::in_item_t it;
    it.opcode = op;
    it.ent.secs = s;
    it.ent.nanos = n;
    it.ent.size = {$urandom, $urandom};
    it.ent.tag = $urandom;
    return it;
  endfunction

  function automatic tnt_pkg::in_item_t rand_item(int unsigned spread);
    logic [63:0] s;
    logic [29:0] n;
    case ($urandom_range(9))
      0: s = {$urandom, $urandom};
      1: s = 64'h8000_0000_0000_0000 + 64'($urandom_range(3));
      2: s = 64'h7fff_ffff_ffff_fffc + 64'($urandom_range(3));
      default: s = 64'($signed($urandom_range(spread)) - $signed(spread / 2));
    endcase
    n = 30'(($urandom_range(7) == 0) ? $urandom : $urandom_range(3));
    return make_item(($urandom_range(7) == 0) ? tnt_pkg::OpDump : tnt_pkg::OpOffer, s, n);
  endfunction

  task automatic drain();
    while (items_pending.size() > 0 || in_ch.valid || results_due.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_keep(logic [5:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    set_keep(v);
  endtask

  initial begin
    logic [5:0] keeps [6] = '{6'd3, 6'd0, 6'd32, 6'd63, 6'd1, 6'd20};
    tnt_pkg::in_item_t it;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset keep_count, empty dump, extremes, ties, odd nanos
    items_pending.push_back(make_item(tnt_pkg::OpDump, 0, 0));
    items_pending.push_back(make_item(tnt_pkg::OpOffer, 64'h8000_0000_0000_0000, 0));
    items_pending.push_back(make_item(tnt_pkg::OpOffer, 64'h7fff_ffff_ffff_ffff,
                                      30'h3fff_ffff));
    items_pending.push_back(make_item(tnt_pkg::OpOffer, 5, 999999999));
    items_pending.push_back(make_item(tnt_pkg::OpOffer, 5, 999999999));
    items_pending.push_back(make_item(tnt_pkg::OpOffer, '1, 1000000000));
    it = make_item(tnt_pkg::OpOffer, 0, 0);
    it.ent.size = '1; it.ent.tag = '1;
    items_pending.push_back(it);
    items_pending.push_back(make_item(tnt_pkg::OpDump, '1, '1));
    drain();
    // small store: fill, tie rejected when full, newer replaces oldest
    write_keep(6'd2);
    items_pending.push_back(make_item(tnt_pkg::OpOffer, 10, 0));
    items_pending.push_back(make_item(tnt_pkg::OpOffer, 20, 0));
    items_pending.push_back(make_item(tnt_pkg::OpOffer, 10, 0));
    items_pending.push_back(make_item(tnt_pkg::OpOffer, 9, 5));
    items_pending.push_back(make_item(tnt_pkg::OpOffer, 15, 0));
    items_pending.push_back(make_item(tnt_pkg::OpDump, 0, 0));
    write_keep(6'd0);
    items_pending.push_back(make_item(tnt_pkg::OpOffer, 1, 1));
    items_pending.push_back(make_item(tnt_pkg::OpDump, 0, 0));

    // random phases over several keep_count settings
    foreach (keeps[k]) begin
      write_keep(keeps[k]);
      for (int i = 0; i < 35; i++) begin
        items_pending.push_back(rand_item((k % 2) ? 8 : 1000));
        if (i == 19) begin
          // sender holds until all results are back
          while (items_pending.size() > 0 || in_ch.valid) @(posedge clk);
          hold_sender = 1'b1;
          while (results_due.size() > 0) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
      items_pending.push_back(make_item(tnt_pkg::OpDump, 0, 0));
    end
    drain();
    repeat (200) @(posedge clk);

    $display("covered %0d offers and %0d dumps, %0d result items checked",
             offers_seen, dumps_seen, results_seen);
    if (fail_cnt == 0 && results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
